// ===== rtl/irg_pkg.sv =====
package irg_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int WORD_W      = 32;
    localparam int IDX_W       = 8;

    localparam logic [WORD_W-1:0] GOLDEN = 32'h9e37_79b9;

    typedef enum logic [1:0] {
        CMD_SEED  = 2'd0,
        CMD_FILL  = 2'd1,
        CMD_INIT  = 2'd2,
        CMD_DRAW  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_INIT,
        ST_PRE,
        ST_SRD,
        ST_MIX,
        ST_WR,
        ST_RF0,
        ST_RF1,
        ST_RF2,
        ST_RF3,
        ST_RF4,
        ST_RF5,
        ST_DRAW,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [IDX_W-1:0]  seed_index;
        logic [WORD_W-1:0] seed_value;
        logic              use_seed;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] random_word;
        logic              word_valid;
    } out_item_t;

    typedef logic [7:0][WORD_W-1:0] mix_vec_t;

    typedef struct packed {
        logic              load;
        logic              step;
        logic [2:0]        step_idx;
        logic              add;
        logic [2:0]        add_idx;
        logic [WORD_W-1:0] add_val;
    } mix_ctrl_t;

    function automatic logic [WORD_W-1:0] mix_shift(input logic [2:0] j,
                                                   input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] r;
        case (j)
            3'd0:    r = v << 11;
            3'd1:    r = v >> 2;
            3'd2:    r = v << 8;
            3'd3:    r = v >> 16;
            3'd4:    r = v << 10;
            3'd5:    r = v >> 4;
            3'd6:    r = v << 8;
            default: r = v >> 9;
        endcase
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] acc_shift(input logic [1:0] j,
                                                   input logic [WORD_W-1:0] a);
        logic [WORD_W-1:0] r;
        case (j)
            2'd0:    r = a ^ (a << 13);
            2'd1:    r = a ^ (a >> 6);
            2'd2:    r = a ^ (a << 2);
            default: r = a ^ (a >> 16);
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/irg_ram.sv =====
module irg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/irg_mix.sv =====
module irg_mix (
    input  logic                clk,
    input  irg_pkg::mix_ctrl_t  ctrl,
    output irg_pkg::mix_vec_t   vec
);
    import irg_pkg::*;

    mix_vec_t v_reg;
    mix_vec_t v_next;
    logic [WORD_W-1:0] nj;
    logic [2:0] j1;
    logic [2:0] j2;
    logic [2:0] j3;

    always_comb
    begin
        j1 = ctrl.step_idx + 3'd1;
        j2 = ctrl.step_idx + 3'd2;
        j3 = ctrl.step_idx + 3'd3;
        nj = v_reg[ctrl.step_idx] ^ mix_shift(ctrl.step_idx, v_reg[j1]);
        v_next = v_reg;
        if (ctrl.load)
        begin
            for (int k = 0; k < 8; k++)
            begin
                v_next[k] = GOLDEN;
            end
        end
        else if (ctrl.step)
        begin
            v_next[ctrl.step_idx] = nj;
            v_next[j3] = v_reg[j3] + nj;
            v_next[j1] = v_reg[j1] + v_reg[j2];
        end
        else if (ctrl.add)
        begin
            v_next[ctrl.add_idx] = v_reg[ctrl.add_idx] + ctrl.add_val;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
    end

    assign vec = v_reg;

endmodule

// ===== rtl/isaac_random_generator.sv =====
// isaac random generator, 32-bit words
// input channel in_valid / in_stall carries one command item; one result
// item per command leaves on out_valid / out_stall
// seed write: both tables written on acceptance; draw: buffer read in ST_DRAW
// every 256th draw refills the buffer, stepping each entry through ST_RF0 to
// ST_RF5, set by the single read port of the state memory
// initialize: 32 mix steps, then per 8-word block a mix and write-back unseeded,
// or a seed read, add, mix and write-back per block and pass seeded (two
// passes), then two refills
// fill constant adds a sweep over both memories before initialize
// in_stall is high from acceptance until the result is in the output register
// a stalled result holds in the output register; the next item is taken
// meanwhile and its result waits until the register frees
// reset clears control state and accumulators and sets mod_reg (modified formula);
// the tables are undefined until seeded or initialized
module isaac_random_generator (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_enable,
    input  logic                 cfg_write_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  irg_pkg::in_item_t    in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output irg_pkg::out_item_t   out_item
);
    import irg_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic              mod_reg;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [4:0]        blk_reg, blk_next;
    logic              pass_reg, pass_next;
    logic              again_reg, again_next;
    logic              seeded_reg, seeded_next;
    logic [WORD_W-1:0] fill_reg, fill_next;
    logic [WORD_W-1:0] x_reg, x_next;
    logic [WORD_W-1:0] y_reg, y_next;
    logic [WORD_W-1:0] a_reg, a_next;
    logic [WORD_W-1:0] b_reg, b_next;
    logic [WORD_W-1:0] rc_reg, rc_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic              wv_reg, wv_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg, out_item_next;

    logic              accept;
    logic              out_free;
    logic              rf_start;
    logic [IDX_W-1:0]  blk_addr;
    logic [WORD_W-1:0] y_calc;
    logic [WORD_W-1:0] b_calc;

    logic              s_we, r_we;
    logic [IDX_W-1:0]  s_waddr, s_raddr, r_waddr, r_raddr;
    logic [WORD_W-1:0] s_wdata, s_rdata, r_wdata, r_rdata;

    mix_ctrl_t mix_ctrl;
    mix_vec_t  mix_vec;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign blk_addr  = {blk_reg, cnt_reg[2:0]};
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    irg_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_DEPTH)) u_state_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    irg_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_DEPTH)) u_result_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    irg_mix u_mix (
        .clk  (clk),
        .ctrl (mix_ctrl),
        .vec  (mix_vec)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_item.cmd)
                        CMD_SEED: state_next = ST_DONE;
                        CMD_FILL: state_next = ST_FILL;
                        CMD_INIT: state_next = ST_INIT;
                        default:  state_next = ST_DRAW;
                    endcase
                end
            end
            ST_FILL: if (idx_reg == 8'hff) state_next = ST_INIT;
            ST_INIT: state_next = ST_PRE;
            ST_PRE:
            begin
                if (cnt_reg == 4'hf && blk_reg[0])
                begin
                    state_next = seeded_reg ? ST_SRD : ST_MIX;
                end
            end
            ST_SRD: if (cnt_reg == 4'd8) state_next = ST_MIX;
            ST_MIX: if (cnt_reg == 4'd7) state_next = ST_WR;
            ST_WR:
            begin
                if (cnt_reg == 4'd7)
                begin
                    if (blk_reg == 5'h1f)
                    begin
                        state_next = (!pass_reg && seeded_reg) ? ST_SRD : ST_RF0;
                    end
                    else
                    begin
                        state_next = seeded_reg ? ST_SRD : ST_MIX;
                    end
                end
            end
            ST_RF0: state_next = ST_RF1;
            ST_RF1: state_next = ST_RF2;
            ST_RF2: state_next = ST_RF3;
            ST_RF3: state_next = ST_RF4;
            ST_RF4: state_next = ST_RF5;
            ST_RF5:
            begin
                if (idx_reg == 8'hff && !again_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_RF0;
                end
            end
            ST_DRAW: state_next = (pos_reg == 8'hff) ? ST_RF0 : ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        idx_next       = idx_reg;
        blk_next       = blk_reg;
        pass_next      = pass_reg;
        again_next     = again_reg;
        seeded_next    = seeded_reg;
        fill_next      = fill_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        rc_next        = rc_reg;
        pos_next       = pos_reg;
        word_next      = word_reg;
        wv_next        = wv_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && out_stall;

        s_we = 1'b0; s_waddr = idx_reg; s_wdata = fill_reg; s_raddr = idx_reg;
        r_we = 1'b0; r_waddr = idx_reg; r_wdata = fill_reg; r_raddr = blk_addr;

        mix_ctrl = '0;
        mix_ctrl.step_idx = cnt_reg[2:0];
        mix_ctrl.add_idx  = cnt_reg[2:0] - 3'd1;
        mix_ctrl.add_val  = pass_reg ? s_rdata : r_rdata;

        y_calc = mod_reg ? (a_reg ^ (b_reg + s_rdata)) : (a_reg + b_reg + s_rdata);
        b_calc = mod_reg ? (a_reg ^ (s_rdata + x_reg)) : (s_rdata + x_reg);

        cnt_next = (state_next != state_reg) ? 4'd0 : cnt_reg + 4'd1;
        rf_start = (state_next == ST_RF0) && (state_reg != ST_RF5 || idx_reg == 8'hff);

        case (state_reg)
            ST_IDLE:
            begin
                r_raddr = pos_reg;
                if (accept)
                begin
                    idx_next    = '0;
                    word_next   = '0;
                    wv_next     = (in_item.cmd == CMD_DRAW);
                    seeded_next = (in_item.cmd == CMD_FILL) || in_item.use_seed;
                    fill_next   = in_item.seed_value;
                    if (in_item.cmd == CMD_SEED)
                    begin
                        s_we = 1'b1; s_waddr = in_item.seed_index;
                        s_wdata = in_item.seed_value;
                        r_we = 1'b1; r_waddr = in_item.seed_index;
                        r_wdata = in_item.seed_value;
                    end
                end
            end
            ST_FILL:
            begin
                s_we = 1'b1;
                r_we = 1'b1;
                idx_next = idx_reg + 8'd1;
            end
            ST_INIT:
            begin
                mix_ctrl.load = 1'b1;
                a_next = '0; b_next = '0; rc_next = '0;
                pos_next = '0; blk_next = '0; pass_next = 1'b0;
            end
            ST_PRE:
            begin
                // 32 steps: blk bit 0 extends the 4-bit count
                mix_ctrl.step = 1'b1;
                mix_ctrl.step_idx = cnt_reg[2:0];
                if (cnt_reg == 4'hf)
                begin
                    blk_next = blk_reg[0] ? 5'd0 : 5'd1;
                end
                if (state_next != state_reg)
                begin
                    cnt_next = 4'd0;
                end
            end
            ST_SRD:
            begin
                s_raddr = blk_addr;
                r_raddr = blk_addr;
                mix_ctrl.add = (cnt_reg != 4'd0);
            end
            ST_MIX:
            begin
                mix_ctrl.step = 1'b1;
            end
            ST_WR:
            begin
                s_we = 1'b1;
                s_waddr = blk_addr;
                s_wdata = mix_vec[cnt_reg[2:0]];
                if (cnt_reg == 4'd7)
                begin
                    blk_next = blk_reg + 5'd1;
                    if (blk_reg == 5'h1f)
                    begin
                        if (!pass_reg && seeded_reg)
                        begin
                            pass_next = 1'b1;
                        end
                        else
                        begin
                            again_next = 1'b1;
                        end
                    end
                end
            end
            ST_RF0:
            begin
                s_raddr = idx_reg;
            end
            ST_RF1:
            begin
                x_next  = s_rdata;
                a_next  = acc_shift(idx_reg[1:0], a_reg);
                s_raddr = idx_reg + 8'd128;
            end
            ST_RF2:
            begin
                a_next  = a_reg + s_rdata;
                s_raddr = x_reg[9:2];
            end
            ST_RF3:
            begin
                y_next  = y_calc;
                s_we    = 1'b1;
                s_waddr = idx_reg;
                s_wdata = y_calc;
            end
            ST_RF4:
            begin
                s_raddr = y_reg[17:10];
            end
            ST_RF5:
            begin
                b_next  = b_calc;
                r_we    = 1'b1;
                r_waddr = idx_reg;
                r_wdata = b_calc;
                idx_next = idx_reg + 8'd1;
                if (idx_reg == 8'hff)
                begin
                    again_next = 1'b0;
                end
            end
            ST_DRAW:
            begin
                word_next  = r_rdata;
                pos_next   = pos_reg + 8'd1;
                again_next = 1'b0;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_item_next.random_word = word_reg;
                    out_item_next.word_valid  = wv_reg;
                end
            end
            default:
            begin
            end
        endcase

        // refill entry: bump the round counter into accumulator b
        if (rf_start)
        begin
            rc_next = rc_reg + 32'd1;
            b_next  = b_next + rc_reg + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mod_reg       <= 1'b1;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            blk_reg       <= '0;
            pass_reg      <= 1'b0;
            again_reg     <= 1'b0;
            seeded_reg    <= 1'b0;
            a_reg         <= '0;
            b_reg         <= '0;
            rc_reg        <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_write_enable)
            begin
                mod_reg <= cfg_write_data;
            end
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            blk_reg       <= blk_next;
            pass_reg      <= pass_next;
            again_reg     <= again_next;
            seeded_reg    <= seeded_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            rc_reg        <= rc_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_reg     <= fill_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        word_reg     <= word_next;
        wv_reg       <= wv_next;
        out_item_reg <= out_item_next;
    end

`ifndef SYNTHESIS
    a_draw_enters: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_item.cmd == CMD_DRAW |=> state_reg == ST_DRAW)
        else $error("draw item did not start a buffer read");

    a_refill_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RF5 && idx_reg == 8'hff && !again_reg |=> state_reg == ST_DONE)
        else $error("last refill did not finish");

    a_init_clears: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_INIT |=> a_reg == '0 && rc_reg == '0 && pos_reg == '0)
        else $error("initialize did not clear accumulators");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result item raised outside completion");
`endif

endmodule

// ===== tb/isaac_checker.sv =====
`timescale 1ns / 1ps

module isaac_checker
    import irg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_write_enable,
    input  logic      cfg_write_data,
    input  logic      in_valid,
    input  logic      in_stall,
    input  in_item_t  in_item,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_item_t out_item,
    output int        outstanding,
    output int        errors
);

    logic [31:0] state_mem [TABLE_DEPTH];
    logic [31:0] result_mem [TABLE_DEPTH];
    logic [31:0] acc_a;
    logic [31:0] acc_b;
    logic [31:0] round_cnt;
    logic [7:0]  draw_pos;
    logic        modified;
    logic [31:0] mv [8];
    out_item_t   expected_words [$];

    initial
    begin
        outstanding = 0;
        errors      = 0;
        acc_a       = '0;
        acc_b       = '0;
        round_cnt   = '0;
        draw_pos    = '0;
        modified    = 1'b1;
    end

    task automatic mix_words();
        mv[0] ^= mv[1] << 11; mv[3] += mv[0]; mv[1] += mv[2];
        mv[1] ^= mv[2] >> 2;  mv[4] += mv[1]; mv[2] += mv[3];
        mv[2] ^= mv[3] << 8;  mv[5] += mv[2]; mv[3] += mv[4];
        mv[3] ^= mv[4] >> 16; mv[6] += mv[3]; mv[4] += mv[5];
        mv[4] ^= mv[5] << 10; mv[7] += mv[4]; mv[5] += mv[6];
        mv[5] ^= mv[6] >> 4;  mv[0] += mv[5]; mv[6] += mv[7];
        mv[6] ^= mv[7] << 8;  mv[1] += mv[6]; mv[7] += mv[0];
        mv[7] ^= mv[0] >> 9;  mv[2] += mv[7]; mv[0] += mv[1];
    endtask

    task automatic refill_buffer();
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] a;
        logic [31:0] b;
        round_cnt = round_cnt + 32'd1;
        a = acc_a;
        b = acc_b + round_cnt;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            x = state_mem[i];
            case (i % 4)
                0:       a ^= a << 13;
                1:       a ^= a >> 6;
                2:       a ^= a << 2;
                default: a ^= a >> 16;
            endcase
            a += state_mem[(i + 128) % TABLE_DEPTH];
            if (modified)
            begin
                y = a ^ (b + state_mem[x[9:2]]);
                state_mem[i] = y;
                b = a ^ (state_mem[y[17:10]] + x);
            end
            else
            begin
                y = a + b + state_mem[x[9:2]];
                state_mem[i] = y;
                b = state_mem[y[17:10]] + x;
            end
            result_mem[i] = b;
        end
        acc_a = a;
        acc_b = b;
    endtask

    task automatic init_state(input logic seeded);
        acc_a     = '0;
        acc_b     = '0;
        round_cnt = '0;
        for (int k = 0; k < 8; k++)
            mv[k] = GOLDEN;
        for (int k = 0; k < 4; k++)
            mix_words();
        for (int i = 0; i < TABLE_DEPTH; i += 8)
        begin
            if (seeded)
                for (int k = 0; k < 8; k++)
                    mv[k] += result_mem[i + k];
            mix_words();
            for (int k = 0; k < 8; k++)
                state_mem[i + k] = mv[k];
        end
        if (seeded)
        begin
            for (int i = 0; i < TABLE_DEPTH; i += 8)
            begin
                for (int k = 0; k < 8; k++)
                    mv[k] += state_mem[i + k];
                mix_words();
                for (int k = 0; k < 8; k++)
                    state_mem[i + k] = mv[k];
            end
        end
        refill_buffer();
        refill_buffer();
        draw_pos = '0;
    endtask

    task automatic predict_word(input in_item_t it);
        out_item_t res;
        res = '0;
        case (cmd_t'(it.cmd))
            CMD_SEED:
            begin
                state_mem[it.seed_index]  = it.seed_value;
                result_mem[it.seed_index] = it.seed_value;
            end
            CMD_FILL:
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    state_mem[i]  = it.seed_value;
                    result_mem[i] = it.seed_value;
                end
                init_state(1'b1);
            end
            CMD_INIT:
                init_state(it.use_seed);
            default:
            begin
                res.random_word = result_mem[draw_pos];
                res.word_valid  = 1'b1;
                draw_pos = draw_pos + 8'd1;
                if (draw_pos == 8'd0)
                    refill_buffer();
            end
        endcase
        expected_words.push_back(res);
    endtask

    always @(posedge clk)
    begin
        out_item_t exp_w;
        if (rst_n)
        begin
            if (cfg_write_enable)
                modified = cfg_write_data;
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected result item %h", out_item);
                    errors++;
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (out_item.random_word !== exp_w.random_word)
                    begin
                        $error("random_word expected %h actual %h",
                               exp_w.random_word, out_item.random_word);
                        errors++;
                    end
                    if (out_item.word_valid !== exp_w.word_valid)
                    begin
                        $error("word_valid expected %b actual %b",
                               exp_w.word_valid, out_item.word_valid);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_word(in_item);
            outstanding <= expected_words.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import irg_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int RANDOM_ITEMS   = 1325;

    logic      clk              = 1'b0;
    logic      rst_n            = 1'b0;
    logic      cfg_write_enable = 1'b0;
    logic      cfg_write_data   = 1'b0;
    logic      in_valid         = 1'b0;
    logic      in_stall;
    in_item_t  in_item          = '0;
    logic      out_valid;
    logic      out_stall        = 1'b0;
    out_item_t out_item;
    int        outstanding;
    int        errors;
    int        idle_cycles      = 0;
    logic      sender_quiet     = 1'b0;
    logic      receiver_quiet   = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    isaac_random_generator i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .in_item          (in_item),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_item         (out_item)
    );

    isaac_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .in_item          (in_item),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_item         (out_item),
        .outstanding      (outstanding),
        .errors           (errors)
    );

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side back-pressure
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 199) == 0)
                receiver_quiet = ~receiver_quiet;
            n = receiver_quiet ? 0 : $urandom_range(0, 15);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_cmd(input cmd_t c, input logic [7:0] idx,
                            input logic [31:0] val, input logic use_s);
        in_item_t it;
        int gap;
        if ($urandom_range(0, 199) == 0)
            sender_quiet = ~sender_quiet;
        gap = sender_quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.cmd        = c;
        it.seed_index = idx;
        it.seed_value = val;
        it.use_seed   = use_s;
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain_and_config(input logic value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 || out_valid)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= value;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
    endtask

    task automatic random_cmd();
        int r;
        logic [31:0] val;
        logic [7:0]  idx;
        logic        use_s;
        r = $urandom_range(0, 99);
        idx   = 8'($urandom_range(0, 255));
        use_s = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0:       val = '0;
            1:       val = '1;
            default: val = $urandom;
        endcase
        if (r < 62)
            send_cmd(CMD_DRAW, idx, val, use_s);
        else if (r < 95)
            send_cmd(CMD_SEED, idx, val, use_s);
        else if (r < 99)
            send_cmd(CMD_INIT, idx, val, use_s);
        else
            send_cmd(CMD_FILL, idx, val, use_s);
    endtask

    initial
    begin
        logic cfg_plan [5];
        cfg_plan = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        cfg_plan[4] = 1'($urandom_range(0, 1));
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // tables must be written before any draw
        drain_and_config(1'b1);
        send_cmd(CMD_FILL, 8'd0, 32'h0, 1'b0);
        send_cmd(CMD_DRAW, 8'd0, 32'h0, 1'b0);
        send_cmd(CMD_DRAW, 8'hff, 32'hffff_ffff, 1'b1);
        send_cmd(CMD_SEED, 8'd0, 32'h0, 1'b0);
        send_cmd(CMD_SEED, 8'hff, 32'hffff_ffff, 1'b1);
        send_cmd(CMD_INIT, 8'h00, 32'h0, 1'b1);
        send_cmd(CMD_DRAW, 8'h00, 32'h0, 1'b0);
        send_cmd(CMD_INIT, 8'hff, 32'hffff_ffff, 1'b0);
        send_cmd(CMD_DRAW, 8'h00, 32'h0, 1'b0);
        send_cmd(CMD_FILL, 8'hff, 32'hffff_ffff, 1'b1);
        send_cmd(CMD_DRAW, 8'h00, 32'h0, 1'b0);
        send_cmd(CMD_DRAW, 8'h00, 32'h0, 1'b0);
        send_cmd(CMD_INIT, 8'h5a, 32'ha5a5_5a5a, 1'b1);
        send_cmd(CMD_DRAW, 8'h00, 32'h0, 1'b0);
        drain_and_config(1'b0);
        send_cmd(CMD_INIT, 8'h00, 32'h0, 1'b1);
        send_cmd(CMD_DRAW, 8'h00, 32'h0, 1'b0);
        for (int i = 0; i < 258; i++)
            send_cmd(CMD_DRAW, 8'($urandom_range(0, 255)), $urandom,
                     1'($urandom_range(0, 1)));

        for (int p = 0; p < 5; p++)
        begin
            drain_and_config(cfg_plan[p]);
            for (int i = 0; i < RANDOM_ITEMS / 5; i++)
                random_cmd();
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 || out_valid)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
